// File: hw/rtl/bcrl_pkg.sv
// Burst credit rate limiter package: item structs, item kinds, register
// indexes and reset values. No dependencies.
package bcrl_pkg;

    localparam int unsigned CREDIT_W = 20;
    localparam int unsigned RATE_W   = 16;
    localparam int unsigned ADDR_W   = 48;
    localparam int unsigned LEN_W    = 10;
    localparam int unsigned BEATS_W  = 3;
    // wide enough for four beats of the largest port
    localparam int unsigned COST_W   = 12;
    localparam int unsigned CFG_IDX_W = 2;

    localparam int unsigned SHIFT_FOUR = 9;
    localparam int unsigned SHIFT_TWO  = 8;
    localparam int unsigned SHIFT_ONE  = 7;

    localparam logic [1:0] KIND_REQ    = 2'd0;
    localparam logic [1:0] KIND_TICK   = 2'd1;
    localparam logic [1:0] KIND_RELOAD = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_RD_MAX  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WR_MAX  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RD_RATE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WR_RATE = 2'd3;

    localparam logic [CREDIT_W-1:0] CREDIT_MAX_RST = 20'd4096;
    localparam logic [RATE_W-1:0]   RATE_RST       = 16'd128;

    typedef struct packed {
        logic [1:0]        kind;
        logic              is_write;
        logic [ADDR_W-1:0] req_addr;
        logic [LEN_W-1:0]  req_bytes;
    } t_in_item;

    typedef struct packed {
        logic                granted;
        logic [BEATS_W-1:0]  beat_count;
        logic [LEN_W-1:0]    charge_bytes;
        logic [CREDIT_W-1:0] read_credit_left;
        logic [CREDIT_W-1:0] write_credit_left;
    } t_out_item;

endpackage

// File: hw/rtl/bcrl_cost.sv
// Burst beat count and byte cost of one request from its start offset and length.
// Depends on bcrl_pkg.
module bcrl_cost #(
    parameter int unsigned PORT_BYTES = 128
) (
    input  logic [bcrl_pkg::SHIFT_FOUR-1:0] i_addr_low,
    input  logic [bcrl_pkg::LEN_W-1:0]      i_len,
    output logic [bcrl_pkg::BEATS_W-1:0]    o_beats,
    output logic [bcrl_pkg::COST_W-1:0]     o_cost
);
    import bcrl_pkg::*;

    localparam logic [COST_W-1:0] P1 = COST_W'(PORT_BYTES);
    localparam logic [COST_W-1:0] P2 = COST_W'(2 * PORT_BYTES);
    localparam logic [COST_W-1:0] P3 = COST_W'(3 * PORT_BYTES);
    localparam logic [COST_W-1:0] P4 = COST_W'(4 * PORT_BYTES);
    localparam int unsigned SUM_W = COST_W + 1;

    logic [COST_W-1:0] len_one;
    logic [COST_W-1:0] len_c;
    logic [SUM_W-1:0]  end_four;
    logic [SUM_W-1:0]  end_two;
    logic [SUM_W-1:0]  end_one;
    logic              cross_four;
    logic              cross_two;
    logic              cross_one;
    logic [BEATS_W-1:0] div_beats;

    always_comb begin
        len_one = (i_len == '0) ? COST_W'(1) : COST_W'(i_len);
        len_c   = (len_one > P4) ? P4 : len_one;

        // last byte offset relative to each aligned window
        end_four = SUM_W'(i_addr_low) + SUM_W'(len_c) - SUM_W'(1);
        end_two  = SUM_W'(i_addr_low[SHIFT_TWO-1:0]) + SUM_W'(len_c) - SUM_W'(1);
        end_one  = SUM_W'(i_addr_low[SHIFT_ONE-1:0]) + SUM_W'(len_c) - SUM_W'(1);
        cross_four = (end_four >= SUM_W'(1 << SHIFT_FOUR));
        cross_two  = (end_two  >= SUM_W'(1 << SHIFT_TWO));
        cross_one  = (end_one  >= SUM_W'(1 << SHIFT_ONE));

        // truncated length / PORT_BYTES, length never above four ports
        if (len_c >= P4) begin
            div_beats = 3'd4;
        end else if (len_c >= P3) begin
            div_beats = 3'd3;
        end else if (len_c >= P2) begin
            div_beats = 3'd2;
        end else if (len_c >= P1) begin
            div_beats = 3'd1;
        end else begin
            div_beats = 3'd0;
        end

        if (cross_four) begin
            o_beats = div_beats;
        end else if (cross_two) begin
            o_beats = 3'd4;
        end else if (cross_one) begin
            o_beats = 3'd2;
        end else begin
            o_beats = 3'd1;
        end

        o_cost = COST_W'(o_beats) * P1;
    end

endmodule

// File: hw/rtl/burst_credit_rate_limiter.sv
// Burst credit rate limiter: read and write byte credit buckets for memory requests.
// A request is captured in the input register, checked and charged combinationally,
// and its result goes to the output register; both hold while the output stalls.
// Throughput: one request per cycle unless the result output stalls.
// Reset: both buckets at 4096 bytes, maxima 4096, refill rates 128, pipeline empty.
// Depends on bcrl_pkg and bcrl_cost.
module burst_credit_rate_limiter #(
    parameter int unsigned PORT_BYTES = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  bcrl_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output bcrl_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bcrl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bcrl_pkg::CREDIT_W-1:0]       i_cfg_data
);
    import bcrl_pkg::*;

    t_in_item            r_in;
    logic                r_in_vld;
    t_out_item           r_out;
    t_out_item           n_out;
    logic                r_out_vld;
    logic [CREDIT_W-1:0] r_rd_credit;
    logic [CREDIT_W-1:0] n_rd_credit;
    logic [CREDIT_W-1:0] r_wr_credit;
    logic [CREDIT_W-1:0] n_wr_credit;
    logic [CREDIT_W-1:0] r_rd_max;
    logic [CREDIT_W-1:0] r_wr_max;
    logic [RATE_W-1:0]   r_rd_rate;
    logic [RATE_W-1:0]   r_wr_rate;

    logic                out_free;
    logic                advance;
    logic                in_take;
    logic [BEATS_W-1:0]  beats;
    logic [COST_W-1:0]   cost;
    logic [CREDIT_W-1:0] bucket;
    logic                enough;
    logic [CREDIT_W:0]   rd_sum;
    logic [CREDIT_W:0]   wr_sum;

    assign out_free    = !r_out_vld || !i_out_stall;
    assign advance     = r_in_vld && out_free;
    assign o_in_stall  = r_in_vld && !out_free;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    bcrl_cost #(
        .PORT_BYTES (PORT_BYTES)
    ) u_cost (
        .i_addr_low (r_in.req_addr[SHIFT_FOUR-1:0]),
        .i_len      (r_in.req_bytes),
        .o_beats    (beats),
        .o_cost     (cost)
    );

    always_comb begin
        bucket = r_in.is_write ? r_wr_credit : r_rd_credit;
        enough = (bucket >= CREDIT_W'(cost));
        rd_sum = (CREDIT_W+1)'(r_rd_credit) + (CREDIT_W+1)'(r_rd_rate);
        wr_sum = (CREDIT_W+1)'(r_wr_credit) + (CREDIT_W+1)'(r_wr_rate);

        n_rd_credit            = r_rd_credit;
        n_wr_credit            = r_wr_credit;
        n_out.granted          = 1'b0;
        n_out.beat_count       = '0;
        n_out.charge_bytes     = '0;

        case (r_in.kind)
            KIND_REQ: begin
                n_out.beat_count   = beats;
                n_out.charge_bytes = (cost > COST_W'({LEN_W{1'b1}})) ? {LEN_W{1'b1}}
                                                                     : cost[LEN_W-1:0];
                if (enough) begin
                    n_out.granted = 1'b1;
                    if (r_in.is_write) begin
                        n_wr_credit = r_wr_credit - CREDIT_W'(cost);
                    end else begin
                        n_rd_credit = r_rd_credit - CREDIT_W'(cost);
                    end
                end
            end
            KIND_TICK: begin
                n_rd_credit = (rd_sum > (CREDIT_W+1)'(r_rd_max)) ? r_rd_max
                                                                  : rd_sum[CREDIT_W-1:0];
                n_wr_credit = (wr_sum > (CREDIT_W+1)'(r_wr_max)) ? r_wr_max
                                                                  : wr_sum[CREDIT_W-1:0];
            end
            KIND_RELOAD: begin
                n_rd_credit = r_rd_max;
                n_wr_credit = r_wr_max;
            end
            default: begin
            end
        endcase

        n_out.read_credit_left  = n_rd_credit;
        n_out.write_credit_left = n_wr_credit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
            r_rd_credit <= CREDIT_MAX_RST;
            r_wr_credit <= CREDIT_MAX_RST;
            r_rd_max    <= CREDIT_MAX_RST;
            r_wr_max    <= CREDIT_MAX_RST;
            r_rd_rate   <= RATE_RST;
            r_wr_rate   <= RATE_RST;
        end else begin
            if (out_free) begin
                r_in_vld <= in_take;
            end else if (in_take) begin
                r_in_vld <= 1'b1;
            end
            if (out_free) begin
                r_out_vld <= r_in_vld;
            end
            if (advance) begin
                r_rd_credit <= n_rd_credit;
                r_wr_credit <= n_wr_credit;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_RD_MAX:  r_rd_max  <= i_cfg_data;
                    REG_WR_MAX:  r_wr_max  <= i_cfg_data;
                    REG_RD_RATE: r_rd_rate <= i_cfg_data[RATE_W-1:0];
                    REG_WR_RATE: r_wr_rate <= i_cfg_data[RATE_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule
